@@ src/tick_task_scheduler_core_macros.svh @@
// Assertion macros for the tick task scheduler core.
// Each macro expects clk and arst_n to be visible at the point of use.
`ifndef TICK_TASK_SCHEDULER_CORE_MACROS_SVH
`define TICK_TASK_SCHEDULER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define TTS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define TTS_ASSERT(lbl, prop, msg)
`define TTS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ src/tts_pkg.sv @@
// Shared types and constants of the tick task scheduler.
// No dependencies; used by tick_task_scheduler_core.
`default_nettype none
package tts_pkg;
	localparam int unsigned MAX_RESULTS = 32;
	localparam int unsigned ID_W = 32;
	localparam int unsigned TIME_W = 32;
	localparam int unsigned ORDER_W = 16;
	localparam int unsigned WORD_W = ID_W + TIME_W + TIME_W + ORDER_W;
	localparam logic [7:0] DIV_RESET = 8'd10;

	typedef logic [1:0] cmd_t;
	localparam cmd_t CMD_TICK = 2'd0;
	localparam cmd_t CMD_SCHED = 2'd1;
	localparam cmd_t CMD_CANCEL = 2'd2;

	typedef logic [2:0] status_t;
	localparam status_t ST_SCHEDULED = 3'd0;
	localparam status_t ST_FULL = 3'd1;
	localparam status_t ST_CANCELLED = 3'd2;
	localparam status_t ST_NOT_FOUND = 3'd3;
	localparam status_t ST_FIRED = 3'd4;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_SCAN = 5'b00010,
		S_DECIDE = 5'b00100,
		S_RESP = 5'b01000,
		S_FLUSH = 5'b10000
	} state_t;
endpackage
`default_nettype wire

@@ src/tts_if.sv @@
// Request and result channel interfaces of the tick task scheduler.
// No dependencies.
`default_nettype none
interface tts_req_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [31:0] task_id;
	logic [31:0] due_time;
	logic [31:0] interval_ticks;
	modport source(output valid, cmd, task_id, due_time, interval_ticks, input ready);
	modport sink(input valid, cmd, task_id, due_time, interval_ticks, output ready);
endinterface

interface tts_rsp_if;
	logic valid;
	logic ready;
	logic [2:0] status;
	logic [31:0] task_id_out;
	logic last;
	modport source(output valid, status, task_id_out, last, input ready);
	modport sink(input valid, status, task_id_out, last, output ready);
endinterface
`default_nettype wire

@@ src/tts_ram.sv @@
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none
module tts_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 32
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

@@ src/tick_task_scheduler_core.sv @@
// A schedule request takes a free table slot if any; a cancel scans the table.
// A raw tick that does not complete a time step only advances the sub-tick
// count. A time step runs one selection pass per fired task and a final pass
// unless MAX_RESULTS fired, as every pass reads the task table through its single
// RAM read port. Results leave through an output register; the block holds off
// new requests while it works on one. Depends on tts_pkg, tts_if and tts_ram.
`default_nettype none
`include "tick_task_scheduler_core_macros.svh"
module tick_task_scheduler_core #(
	parameter int unsigned TABLE_DEPTH = 32
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_we,
	input wire logic [7:0] cfg_wdata,
	tts_req_if.sink req,
	tts_rsp_if.source rsp
);
	import tts_pkg::*;

	localparam int unsigned IW = $clog2(TABLE_DEPTH);
	localparam int unsigned FW = $clog2(MAX_RESULTS + 1);

	state_t state_q;
	logic [7:0] div_q, sub_q, sub_next;
	logic [TIME_W-1:0] now_q;
	logic [ORDER_W-1:0] ins_q;
	logic [TABLE_DEPTH-1:0] valid_q, pend_q;
	logic cancel_q, first_q, issue_done_q;
	logic [ID_W-1:0] key_q;
	logic [IW-1:0] idx_q, idx_s1;
	logic scan_s1;
	logic best_vld_q;
	logic [IW-1:0] best_idx_q;
	logic [TIME_W-1:0] best_due_q, best_ivl_q;
	logic [ORDER_W-1:0] best_age_q;
	logic [ID_W-1:0] best_id_q;
	logic held_vld_q;
	logic [ID_W-1:0] held_id_q;
	logic [FW-1:0] fire_cnt_q;
	status_t resp_st_q;
	logic out_vld_q, out_last_q;
	status_t out_st_q;
	logic [ID_W-1:0] out_id_q;

	logic we;
	logic [IW-1:0] waddr;
	logic [WORD_W-1:0] wdata, rdata;
	logic [ID_W-1:0] rd_id;
	logic [TIME_W-1:0] rd_due, rd_ivl;
	logic [ORDER_W-1:0] rd_order, rd_age;
	logic free_found;
	logic [IW-1:0] free_idx;
	logic cand, prec, slot_free, accept;

	tts_ram #(.WIDTH(WORD_W), .DEPTH(TABLE_DEPTH)) u_table (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(idx_q), .rdata(rdata)
	);

	assign {rd_id, rd_due, rd_ivl, rd_order} = rdata;
	assign rd_age = ins_q - rd_order;
	assign accept = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign slot_free = !out_vld_q || rsp.ready;
	assign sub_next = sub_q + 8'd1;
	assign rsp.valid = out_vld_q;
	assign rsp.status = out_st_q;
	assign rsp.task_id_out = out_id_q;
	assign rsp.last = out_last_q;

	always_comb begin
		free_found = 1'b0;
		free_idx = '0;
		for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
			if (!valid_q[i]) begin
				free_found = 1'b1;
				free_idx = IW'(i);
			end
		end
	end

	always_comb begin
		if (cancel_q) begin
			cand = valid_q[idx_s1] && (rd_id == key_q);
		end else if (first_q) begin
			cand = valid_q[idx_s1] && (rd_due <= now_q);
		end else begin
			cand = pend_q[idx_s1];
		end
		prec = (rd_due < best_due_q) || ((rd_due == best_due_q) && (rd_age > best_age_q));
	end

	always_comb begin
		we = 1'b0;
		waddr = free_idx;
		wdata = {req.task_id, req.due_time, req.interval_ticks, ins_q};
		if (state_q == S_IDLE) begin
			we = accept && (req.cmd == CMD_SCHED) && free_found;
		end else if (state_q == S_DECIDE) begin
			waddr = best_idx_q;
			wdata = {best_id_q, now_q + best_ivl_q, best_ivl_q, ins_q};
			we = !cancel_q && best_vld_q && (best_ivl_q != '0)
				&& (!held_vld_q || slot_free);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			div_q <= DIV_RESET;
			sub_q <= '0;
			now_q <= '0;
			ins_q <= '0;
			valid_q <= '0;
			pend_q <= '0;
			scan_s1 <= 1'b0;
			issue_done_q <= 1'b0;
			best_vld_q <= 1'b0;
			held_vld_q <= 1'b0;
			fire_cnt_q <= '0;
			out_vld_q <= 1'b0;
			cancel_q <= 1'b0;
			first_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				div_q <= cfg_wdata;
			end
			if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			scan_s1 <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						key_q <= req.task_id;
						idx_q <= '0;
						issue_done_q <= 1'b0;
						best_vld_q <= 1'b0;
						case (req.cmd)
							CMD_TICK: begin
								if (sub_next < div_q) begin
									sub_q <= sub_next;
								end else begin
									sub_q <= '0;
									now_q <= now_q + 1'b1;
									cancel_q <= 1'b0;
									first_q <= 1'b1;
									fire_cnt_q <= '0;
									state_q <= S_SCAN;
								end
							end
							CMD_SCHED: begin
								if (free_found) begin
									valid_q[free_idx] <= 1'b1;
									ins_q <= ins_q + 1'b1;
									resp_st_q <= ST_SCHEDULED;
								end else begin
									resp_st_q <= ST_FULL;
								end
								state_q <= S_RESP;
							end
							CMD_CANCEL: begin
								cancel_q <= 1'b1;
								state_q <= S_SCAN;
							end
							default: begin
							end
						endcase
					end
				end
				S_SCAN: begin
					if (!issue_done_q) begin
						scan_s1 <= 1'b1;
						idx_s1 <= idx_q;
						if (idx_q == IW'(TABLE_DEPTH - 1)) begin
							issue_done_q <= 1'b1;
						end else begin
							idx_q <= idx_q + 1'b1;
						end
					end
					if (scan_s1) begin
						if (first_q && !cancel_q) begin
							pend_q[idx_s1] <= cand;
						end
						if (cand && (!best_vld_q || prec)) begin
							best_vld_q <= 1'b1;
							best_idx_q <= idx_s1;
							best_due_q <= rd_due;
							best_age_q <= rd_age;
							best_id_q <= rd_id;
							best_ivl_q <= rd_ivl;
						end
						if (idx_s1 == IW'(TABLE_DEPTH - 1)) begin
							state_q <= S_DECIDE;
						end
					end
				end
				S_DECIDE: begin
					if (cancel_q) begin
						if (best_vld_q) begin
							valid_q[best_idx_q] <= 1'b0;
							resp_st_q <= ST_CANCELLED;
						end else begin
							resp_st_q <= ST_NOT_FOUND;
						end
						state_q <= S_RESP;
					end else if (!best_vld_q) begin
						state_q <= held_vld_q ? S_FLUSH : S_IDLE;
					end else if (!held_vld_q || slot_free) begin
						if (held_vld_q) begin
							out_vld_q <= 1'b1;
							out_st_q <= ST_FIRED;
							out_id_q <= held_id_q;
							out_last_q <= 1'b0;
						end
						held_vld_q <= 1'b1;
						held_id_q <= best_id_q;
						pend_q[best_idx_q] <= 1'b0;
						if (best_ivl_q != '0) begin
							ins_q <= ins_q + 1'b1;
						end else begin
							valid_q[best_idx_q] <= 1'b0;
						end
						fire_cnt_q <= fire_cnt_q + 1'b1;
						first_q <= 1'b0;
						idx_q <= '0;
						issue_done_q <= 1'b0;
						best_vld_q <= 1'b0;
						if (fire_cnt_q == FW'(MAX_RESULTS - 1)) begin
							state_q <= S_FLUSH;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_RESP: begin
					if (slot_free) begin
						out_vld_q <= 1'b1;
						out_st_q <= resp_st_q;
						out_id_q <= key_q;
						out_last_q <= 1'b1;
						state_q <= S_IDLE;
					end
				end
				S_FLUSH: begin
					if (slot_free) begin
						out_vld_q <= 1'b1;
						out_st_q <= ST_FIRED;
						out_id_q <= held_id_q;
						out_last_q <= 1'b1;
						held_vld_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`TTS_ASSERT(a_fire_cap, fire_cnt_q <= FW'(MAX_RESULTS), "firing count passed its cap")
	`TTS_ASSERT(a_idle_no_held, !(state_q == S_IDLE && held_vld_q), "held firing left behind")
	`TTS_ASSERT(a_flush_held, !(state_q == S_FLUSH) || held_vld_q, "flush with nothing held")
	`TTS_ASSERT_NEXT(a_resp_done, state_q == S_RESP && slot_free, out_vld_q && out_last_q,
		"response not presented")
endmodule
`default_nettype wire
